// ----- design/segregated_bin_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// Segregated bin allocator assertion macros
// Shorthand for the concurrent checks used in the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef SEGREGATED_BIN_ALLOCATOR_ASSERT_SVH
`define SEGREGATED_BIN_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SBA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sba: assertion failed");

// Next-cycle implication, disabled during reset.
`define SBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sba: assertion failed");

`endif

// ----- design/sba_pkg.sv -----
// ----------------------------------------------------------------------------
// Segregated bin allocator package
// Heap geometry, field widths, command and status codes, transfer structs.
// ----------------------------------------------------------------------------
`default_nettype none

package sba_pkg;

   localparam int GRANULE_BYTES = 16;
   localparam int BIN_COUNT     = 32;
   localparam int HEADER_BYTES  = 16;
   localparam int HEAP_GRANULES = 4096;

   localparam int GRAN_SHIFT = $clog2(GRANULE_BYTES);
   localparam int GRAN_W     = $clog2(HEAP_GRANULES);
   localparam int BUMP_W     = GRAN_W + 1;

   localparam int CMD_W    = 2;
   localparam int SIZE_W   = 16;
   localparam int ADDR_W   = 16;
   localparam int STATUS_W = 2;
   localparam int BIN_W    = 5;
   localparam int COPY_W   = 9;

   // Header plus request, rounded up to granules, before the range check
   localparam int BIN_SUM_W = SIZE_W + 2;
   // Granule number scaled to bytes plus header, with room to detect overflow
   localparam int PAY_W     = BUMP_W + GRAN_SHIFT + 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_FREE   = 2'd1,
      CMD_RESIZE = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 2'd0,
      ST_TOO_LARGE = 2'd1,
      ST_HEAP_FULL = 2'd2,
      ST_NULL      = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type             command;
      logic [SIZE_W-1:0]   request_size;
      logic [ADDR_W-1:0]   data_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   result_address;
      status_type          status;
      logic [BIN_W-1:0]    bin_index;
      logic                moved;
      logic [COPY_W-1:0]   copy_length;
   } rsp_type;

endpackage

`default_nettype wire

// ----- design/sba_if.sv -----
// ----------------------------------------------------------------------------
// Segregated bin allocator channels
// Valid/ready request and response channels with their payload fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface sba_req_if import sba_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [SIZE_W-1:0]   request_size;
   logic [ADDR_W-1:0]   data_address;

   modport source (output valid, output command, output request_size,
                   output data_address, input ready);
   modport sink   (input valid, input command, input request_size,
                   input data_address, output ready);
endinterface

interface sba_rsp_if import sba_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ADDR_W-1:0]   result_address;
   logic [STATUS_W-1:0] status;
   logic [BIN_W-1:0]    bin_index;
   logic                moved;
   logic [COPY_W-1:0]   copy_length;

   modport source (output valid, output result_address, output status,
                   output bin_index, output moved, output copy_length,
                   input ready);
   modport sink   (input valid, input result_address, input status,
                   input bin_index, input moved, input copy_length,
                   output ready);
endinterface

`default_nettype wire

// ----- design/sba_engine.sv -----
// ----------------------------------------------------------------------------
// Segregated bin allocator engine
// Command sequencer over the per-granule link/size memory and the bin heads.
// ----------------------------------------------------------------------------
`default_nettype none

`include "segregated_bin_allocator_assert.svh"

module sba_engine import sba_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire req_type req_in,
   output logic         idle,
   output logic         done,
   input  wire logic    take,
   output rsp_type      result
);

   localparam int MEM_W = 1 + GRAN_W + BIN_W;

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_START   = 6'b000010,
      S_LOOKUP  = 6'b000100,
      S_POP     = 6'b001000,
      S_RELEASE = 6'b010000,
      S_DONE    = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   cmd_type              cmd_ff;
   logic [SIZE_W-1:0]    size_ff;
   logic [ADDR_W-1:0]    addr_ff;
   rsp_type              res_ff, res_in;
   logic [BUMP_W-1:0]    bump_ff, bump_in;
   logic [BIN_W-1:0]     old_bin_ff, old_bin_in;

   // Bin list heads: link in plain registers, valid bit cleared by reset
   logic [GRAN_W-1:0]    head_ff [BIN_COUNT];
   logic                 head_valid_ff [BIN_COUNT];

   // Per-granule word: link valid, next link, stored bin
   logic [MEM_W-1:0]     gran_mem [HEAP_GRANULES];
   logic [MEM_W-1:0]     mem_rd_ff;

   logic                 mem_re, mem_we;
   logic [GRAN_W-1:0]    mem_raddr, mem_waddr;
   logic [MEM_W-1:0]     mem_wdata;

   logic                 head_we, head_wvalid;
   logic [BIN_W-1:0]     head_widx, head_ridx;
   logic [GRAN_W-1:0]    head_wlink, head_q;
   logic                 hv_q;

   logic [BIN_SUM_W-1:0] bin_sum;
   logic                 too_large;
   logic [BIN_W-1:0]     alloc_bin;
   logic [ADDR_W-1:0]    addr_off;
   logic [GRAN_W-1:0]    gran;
   logic                 rd_lv;
   logic [GRAN_W-1:0]    rd_link;
   logic [BIN_W-1:0]     rd_size;
   logic [COPY_W-1:0]    old_bytes;
   logic                 same_size;
   logic [COPY_W-1:0]    copy_len;
   logic [BUMP_W:0]      bump_end;
   logic [PAY_W-1:0]     bump_pay, head_pay;
   logic                 heap_full;
   logic                 alloc_active;
   logic                 is_resize;

   // Bin from request: header added, rounded up to whole granules
   assign bin_sum   = (BIN_SUM_W'(size_ff) + BIN_SUM_W'(HEADER_BYTES + GRANULE_BYTES - 1))
                      >> GRAN_SHIFT;
   assign too_large = bin_sum >= BIN_SUM_W'(BIN_COUNT);
   assign alloc_bin = bin_sum[BIN_W-1:0];

   // Granule behind a payload pointer, wrapping below the header
   assign addr_off = addr_ff - ADDR_W'(HEADER_BYTES);
   assign gran     = addr_off[GRAN_SHIFT +: GRAN_W];

   assign rd_lv   = mem_rd_ff[MEM_W-1];
   assign rd_link = mem_rd_ff[BIN_W +: GRAN_W];
   assign rd_size = mem_rd_ff[BIN_W-1:0];

   assign old_bytes = COPY_W'(rd_size) << GRAN_SHIFT;
   assign same_size = size_ff == SIZE_W'(old_bytes);
   assign copy_len  = (size_ff < SIZE_W'(old_bytes)) ? size_ff[COPY_W-1:0] : old_bytes;

   assign bump_end  = (BUMP_W+1)'(bump_ff) + (BUMP_W+1)'(alloc_bin);
   assign bump_pay  = (PAY_W'(bump_ff) << GRAN_SHIFT) + PAY_W'(HEADER_BYTES);
   assign heap_full = (bump_end > (BUMP_W+1)'(HEAP_GRANULES))
                      || (bump_pay > PAY_W'(2**ADDR_W - 1));

   // One head read port: free and release look at the old block's bin
   assign head_ridx = ((state_ff == S_LOOKUP) && (cmd_ff == CMD_FREE)) ? rd_size :
                      (state_ff == S_RELEASE) ? old_bin_ff : alloc_bin;
   assign head_q    = head_ff[head_ridx];
   assign hv_q      = head_valid_ff[head_ridx];
   assign head_pay  = (PAY_W'(head_q) << GRAN_SHIFT) + PAY_W'(HEADER_BYTES);

   assign is_resize    = cmd_ff == CMD_RESIZE;
   assign alloc_active = ((state_ff == S_START) && (cmd_ff == CMD_ALLOC))
                         || ((state_ff == S_LOOKUP) && is_resize && !same_size);

   always_comb begin
      state_in    = state_ff;
      res_in      = res_ff;
      bump_in     = bump_ff;
      old_bin_in  = old_bin_ff;
      mem_re      = 1'b0;
      mem_raddr   = gran;
      mem_we      = 1'b0;
      mem_waddr   = gran;
      mem_wdata   = {hv_q, head_q, rd_size};
      head_we     = 1'b0;
      head_widx   = head_ridx;
      head_wlink  = gran;
      head_wvalid = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               res_in   = '0;
               state_in = S_START;
            end
         end
         S_START: begin
            if ((cmd_ff == CMD_FREE) || (cmd_ff == CMD_RESIZE)) begin
               if (addr_ff == '0) begin
                  res_in.status = ST_NULL;
                  state_in      = S_DONE;
               end else begin
                  mem_re   = 1'b1;
                  state_in = S_LOOKUP;
               end
            end else if (cmd_ff == CMD_NONE) begin
               state_in = S_DONE;
            end
         end
         S_LOOKUP: begin
            old_bin_in = rd_size;
            if (cmd_ff == CMD_FREE) begin
               // push the block onto its stored bin
               mem_we           = 1'b1;
               head_we          = 1'b1;
               res_in.bin_index = rd_size;
               state_in         = S_DONE;
            end else if (same_size) begin
               res_in.result_address = addr_ff;
               res_in.bin_index      = rd_size;
               state_in              = S_DONE;
            end
         end
         S_POP: begin
            head_we     = 1'b1;
            head_widx   = alloc_bin;
            head_wlink  = rd_link;
            head_wvalid = rd_lv;
            state_in    = is_resize ? S_RELEASE : S_DONE;
         end
         S_RELEASE: begin
            // old block goes back only after the new one is taken
            mem_we   = 1'b1;
            mem_wdata = {hv_q, head_q, old_bin_ff};
            head_we  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (alloc_active) begin
         priority if (too_large) begin
            res_in.status = ST_TOO_LARGE;
            state_in      = S_DONE;
         end else if (hv_q) begin
            mem_re                = 1'b1;
            mem_raddr             = head_q;
            res_in.result_address = head_pay[ADDR_W-1:0];
            res_in.bin_index      = alloc_bin;
            res_in.moved          = is_resize;
            res_in.copy_length    = is_resize ? copy_len : '0;
            state_in              = S_POP;
         end else if (heap_full) begin
            res_in.status = ST_HEAP_FULL;
            state_in      = S_DONE;
         end else begin
            mem_we                = 1'b1;
            mem_waddr             = bump_ff[GRAN_W-1:0];
            mem_wdata             = {1'b0, {GRAN_W{1'b0}}, alloc_bin};
            bump_in               = bump_end[BUMP_W-1:0];
            res_in.result_address = bump_pay[ADDR_W-1:0];
            res_in.bin_index      = alloc_bin;
            res_in.moved          = is_resize;
            res_in.copy_length    = is_resize ? copy_len : '0;
            state_in              = is_resize ? S_RELEASE : S_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         bump_ff  <= '0;
      end else begin
         state_ff <= state_in;
         bump_ff  <= bump_in;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_IDLE) && start) begin
         cmd_ff  <= req_in.command;
         size_ff <= req_in.request_size;
         addr_ff <= req_in.data_address;
      end
      res_ff     <= res_in;
      old_bin_ff <= old_bin_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BIN_COUNT; i++) begin
            head_valid_ff[i] <= 1'b0;
         end
      end else if (head_we) begin
         head_valid_ff[head_widx] <= head_wvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_ff[head_widx] <= head_wlink;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         gran_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rd_ff <= gran_mem[mem_raddr];
      end
   end

   assign idle   = state_ff == S_IDLE;
   assign done   = state_ff == S_DONE;
   assign result = res_ff;

   `SBA_ASSERT_IMPLY(a_bump_bound, clock, reset, 1'b1, bump_ff <= BUMP_W'(HEAP_GRANULES))
   `SBA_ASSERT_NEXT(a_bump_rises, clock, reset, 1'b1, bump_ff >= $past(bump_ff))
   `SBA_ASSERT_IMPLY(a_single_port, clock, reset, mem_we, !mem_re)
   `SBA_ASSERT_IMPLY(a_moved_ok, clock, reset, done && result.moved, result.status == ST_DONE)
   `SBA_ASSERT_NEXT(a_release_push, clock, reset, state_ff == S_RELEASE,
                    head_valid_ff[old_bin_ff])

endmodule

`default_nettype wire

// ----- design/segregated_bin_allocator.sv -----
// ----------------------------------------------------------------------------
// Segregated bin allocator
// Size-class heap allocator with per-bin free lists and a bump pointer.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one command per transfer: allocate, free or resize, with
//   request_size and data_address. rsp_ch returns exactly one result per
//   command: address, status, bin, moved flag and copy length.
//   Commands are handled one at a time by a sequencer around a single-port
//   granule memory with a registered read and the bin head registers.
//   A bump allocate, an unknown command or a command rejected before any
//   lookup goes from start to done; free and resize read the old block in
//   lookup, where a free, same-size or failed resize ends; an allocate from
//   a free list pops its bin, and a moving resize then releases the old block.
//   A new request is taken in the cycle after the previous result is handed
//   to the output register; no new command is taken before the last is done.
//   The output register holds a result while rsp_ch.ready is low; the next
//   request is still accepted and worked on, and waits for that register.
//   Reset clears the bin head valid bits and the bump pointer at once; the
//   granule memory needs no clearing and the block is ready the cycle after.
// ----------------------------------------------------------------------------
`default_nettype none

module segregated_bin_allocator import sba_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   sba_req_if.sink    req_ch,
   sba_rsp_if.source  rsp_ch
);

   logic    eng_idle, eng_done, eng_take, eng_start;
   rsp_type eng_result;
   req_type req_data;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   assign req_data.command      = cmd_type'(req_ch.command);
   assign req_data.request_size = req_ch.request_size;
   assign req_data.data_address = req_ch.data_address;

   assign req_ch.ready = eng_idle;
   assign eng_start    = req_ch.valid && eng_idle;

   // Hand a finished result over when the output register is free or leaving
   assign eng_take     = eng_done && (!rsp_valid_ff || rsp_ch.ready);
   assign rsp_valid_in = eng_take || (rsp_valid_ff && !rsp_ch.ready);

   sba_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .start  (eng_start),
      .req_in (req_data),
      .idle   (eng_idle),
      .done   (eng_done),
      .take   (eng_take),
      .result (eng_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_take) begin
         rsp_data_ff <= eng_result;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.result_address = rsp_data_ff.result_address;
   assign rsp_ch.status         = rsp_data_ff.status;
   assign rsp_ch.bin_index      = rsp_data_ff.bin_index;
   assign rsp_ch.moved          = rsp_data_ff.moved;
   assign rsp_ch.copy_length    = rsp_data_ff.copy_length;

endmodule

`default_nettype wire
